// ----- hw/rtl/rwzo_pkg.sv -----
`default_nettype none

package rwzo_pkg;

  localparam int MAX_HALF_WINDOW_DEF = 16;
  localparam int SAMPLE_BITS_DEF     = 24;

  localparam int HW_W       = 5;
  localparam int THR_W      = 16;
  localparam int THR_FRAC   = 8;
  localparam int LHS_SHIFT  = 2 * THR_FRAC;
  localparam int POS_W      = 32;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  localparam logic [HW_W-1:0]  HW_RESET  = HW_W'(5);
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(768);

  typedef enum logic {
    REG_HALF_WINDOW = 1'b0,
    REG_THRESHOLD   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic done;
    logic flag;
  } judge_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rwzo_ram.sv -----
`default_nettype none

module rwzo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hw/rtl/rwzo_judge.sv -----
`default_nettype none

module rwzo_judge import rwzo_pkg::*; #(
  parameter int MAX_HALF_WINDOW = MAX_HALF_WINDOW_DEF,
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  localparam int DEPTH  = 2 * MAX_HALF_WINDOW + 1,
  localparam int AW     = $clog2(DEPTH),
  localparam int CNT_W  = $clog2(DEPTH + 1),
  localparam int SB     = SAMPLE_BITS,
  localparam int SUM_W  = SB + AW,
  localparam int SQ_W   = 2 * SB - 2 + AW
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CNT_W-1:0] cnt,
  input  logic [SUM_W-1:0] sum,
  input  logic [SQ_W-1:0]  sum_sq,
  input  logic [SB-1:0]    center,
  input  logic [THR_W-1:0] thr,
  output judge_res_t       res
);

  localparam int CQ_W   = SQ_W + CNT_W;
  localparam int SM_W   = SUM_W - 1;
  localparam int S2_W   = 2 * SM_W;
  localparam int D_W    = (CQ_W > S2_W) ? CQ_W : S2_W;
  localparam int DEV_W  = SB + AW + 1;
  localparam int DEVM_W = SB + AW;
  localparam int DEV2_W = 2 * DEVM_W;
  localparam int LHS_W  = DEV2_W + CNT_W;
  localparam int DT_W   = D_W + THR_W;
  localparam int DTT_W  = DT_W + THR_W;
  localparam int RHS_W  = DTT_W + CNT_W;
  localparam int LSH_W  = LHS_W + LHS_SHIFT;
  localparam int CMP_W  = (LSH_W > RHS_W) ? LSH_W : RHS_W;

  logic [4:0]        v_r;

  logic              xc_neg;
  logic [SB-1:0]     xc_mag;
  logic [DEVM_W-1:0] cx_mag;
  logic [DEV_W-1:0]  cx;
  logic [DEV_W-1:0]  dev;
  logic [DEV_W-1:0]  dev_neg;
  logic [DEVM_W-1:0] dev_mag;
  logic [SUM_W-1:0]  sum_neg;
  logic [SM_W-1:0]   s_mag;
  logic [CNT_W-1:0]  cm1;

  logic [CQ_W-1:0]   cq_r;
  logic [S2_W-1:0]   s2_r;
  logic [DEVM_W-1:0] dev_r;

  logic [D_W-1:0]    d_r;
  logic              gtz2_r;
  logic [DEV2_W-1:0] dev2_r;

  logic [LHS_W-1:0]  lhs3_r;
  logic [DT_W-1:0]   dt_r;
  logic              gtz3_r;

  logic [LHS_W-1:0]  lhs4_r;
  logic [DTT_W-1:0]  dtt_r;
  logic              gtz4_r;

  logic [LHS_W-1:0]  lhs5_r;
  logic [RHS_W-1:0]  rhs_r;
  logic              gtz5_r;

  logic [CMP_W-1:0]  lhs_cmp;
  logic [CMP_W-1:0]  rhs_cmp;

  assign xc_neg  = center[SB-1];
  assign xc_mag  = xc_neg ? (-center) : center;
  assign cx_mag  = cnt * xc_mag;
  assign cx      = xc_neg ? (-{1'b0, cx_mag}) : {1'b0, cx_mag};
  assign dev     = cx - {sum[SUM_W-1], sum};
  assign dev_neg = -dev;
  assign dev_mag = dev[DEV_W-1] ? dev_neg[DEVM_W-1:0] : dev[DEVM_W-1:0];
  assign sum_neg = -sum;
  assign s_mag   = sum[SUM_W-1] ? sum_neg[SM_W-1:0] : sum[SM_W-1:0];
  assign cm1     = cnt - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cq_r  <= sum_sq * cnt;
      s2_r  <= s_mag * s_mag;
      dev_r <= dev_mag;
    end
    if (v_r[0]) begin
      gtz2_r <= D_W'(cq_r) > D_W'(s2_r);
      d_r    <= D_W'(cq_r) - D_W'(s2_r);
      dev2_r <= dev_r * dev_r;
    end
    if (v_r[1]) begin
      lhs3_r <= dev2_r * cm1;
      dt_r   <= d_r * thr;
      gtz3_r <= gtz2_r;
    end
    if (v_r[2]) begin
      lhs4_r <= lhs3_r;
      dtt_r  <= dt_r * thr;
      gtz4_r <= gtz3_r;
    end
    if (v_r[3]) begin
      lhs5_r <= lhs4_r;
      rhs_r  <= dtt_r * cnt;
      gtz5_r <= gtz4_r;
    end
  end

  assign lhs_cmp  = CMP_W'({lhs5_r, {LHS_SHIFT{1'b0}}});
  assign rhs_cmp  = CMP_W'(rhs_r);
  assign res.done = v_r[4];
  assign res.flag = gtz5_r && (lhs_cmp > rhs_cmp);

endmodule

`default_nettype wire

// ----- hw/rtl/rolling_window_zscore_outlier.sv -----
// Rolling-window outlier detector: each item is a signed Q12.12 sample with a missing flag
// and a series-start flag; once the centered window of 2W+1 samples is full, the center
// sample is flagged when it is present, at least two samples are valid, the variance is
// positive and it lies more than threshold_q8/256 standard deviations from the mean, and
// its 1-based position in the series is sent out. The window lives in one RAM as a ring
// buffer, so an item takes one read for the dropped sample, then the read-modify-write
// and the center read through the single RAM read port, and, when its center is
// tested, the product chain of the exact square-root-free test; a flagged result may
// wait in the output register while the next item is taken in, and a further flagged
// item is held until that register frees up.
// Writing half_window empties the window but keeps the series position;
// W of zero acts as 1 and W above MAX_HALF_WINDOW acts as MAX_HALF_WINDOW.
`default_nettype none

module rolling_window_zscore_outlier import rwzo_pkg::*; #(
  parameter int MAX_HALF_WINDOW = MAX_HALF_WINDOW_DEF,
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_sample_missing,
  input  logic                   in_series_start,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [POS_W-1:0]       out_outlier_position,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_AW-1:0]      paddr,
  input  logic [CFG_DW-1:0]      pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready
);

  localparam int DEPTH = 2 * MAX_HALF_WINDOW + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SB    = SAMPLE_BITS;
  localparam int SUM_W = SB + AW;
  localparam int SQ_W  = 2 * SB - 2 + AW;
  localparam int ENT_W = SB + 1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_OLD   = 6'b000010,
    ST_UPD   = 6'b000100,
    ST_CTR   = 6'b001000,
    ST_JUDGE = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;

  logic [HW_W-1:0]  hw_r;
  logic [THR_W-1:0] thr_r;
  logic [SUM_W-1:0] sum_r;
  logic [SQ_W-1:0]  sq_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] fill_r;
  logic [AW-1:0]    wp_r;
  logic [POS_W-1:0] pos_r;
  logic             out_valid_r;
  logic [POS_W-1:0] out_pos_r;

  logic [SB-1:0]    x_r;
  logic             miss_r;
  logic             drop_r;
  logic [SUM_W-1:0] old_term_r;
  logic [SQ_W-1:0]  old_sq_r;
  logic [SQ_W-1:0]  x_sq_r;

  logic             acc;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;
  logic [AW-1:0]    w_a;
  logic [CNT_W-1:0] len_c;
  logic [AW-1:0]    len_a;
  logic [AW-1:0]    ctr_addr;
  logic [AW-1:0]    wp_inc;
  logic [CNT_W-1:0] fill_base;
  logic             out_free;
  logic             load_out;
  logic             judge_go;
  logic             test_ok;

  logic             ram_we;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [ENT_W-1:0] ram_rdata;
  logic             rd_ok;
  logic [SB-1:0]    rd_x;
  logic [SB-1:0]    rd_neg;
  logic [SB-1:0]    rd_mag;
  logic [SB-1:0]    x_neg;
  logic [SB-1:0]    x_mag;
  logic [2*SB-1:0]  rd_sq;
  logic [2*SB-1:0]  x_sq;
  logic [SUM_W-1:0] x_ext;

  judge_res_t       jres;

  assign acc      = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign cfg_idx  = reg_idx_t'(paddr[CFG_AW-1]);
  assign pready   = 1'b1;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    if (hw_r == '0) begin
      w_a = AW'(1);
    end else if (int'(hw_r) > MAX_HALF_WINDOW) begin
      w_a = AW'(MAX_HALF_WINDOW);
    end else begin
      w_a = AW'(hw_r);
    end
  end

  assign len_c     = CNT_W'({w_a, 1'b1});
  assign len_a     = AW'(len_c);
  assign ctr_addr  = (wp_r >= w_a) ? (wp_r - w_a) : (wp_r + len_a - w_a);
  assign wp_inc    = (wp_r == len_a - AW'(1)) ? '0 : (wp_r + AW'(1));
  assign fill_base = (fill_r >= len_c) ? (len_c - CNT_W'(1)) : fill_r;

  assign rd_ok  = ram_rdata[ENT_W-1];
  assign rd_x   = ram_rdata[SB-1:0];
  assign rd_neg = -rd_x;
  assign rd_mag = rd_x[SB-1] ? rd_neg : rd_x;
  assign x_neg  = -x_r;
  assign x_mag  = x_r[SB-1] ? x_neg : x_r;
  assign rd_sq  = rd_mag * rd_mag;
  assign x_sq   = x_mag * x_mag;
  assign x_ext  = {{AW{x_r[SB-1]}}, x_r};

  assign ram_wdata = {!miss_r, x_r};
  assign test_ok   = (fill_r == len_c) && rd_ok && (cnt_r >= CNT_W'(2));

  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    judge_go  = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = wp_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ram_re    = 1'b1;
          ram_raddr = in_series_start ? '0 : wp_r;
          state_nxt = ST_OLD;
        end
      end
      ST_OLD: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        ram_we    = 1'b1;
        ram_re    = 1'b1;
        ram_raddr = ctr_addr;
        state_nxt = ST_CTR;
      end
      ST_CTR: begin
        if (test_ok) begin
          judge_go  = 1'b1;
          state_nxt = ST_JUDGE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_JUDGE: begin
        if (jres.done) begin
          if (!jres.flag) begin
            state_nxt = ST_IDLE;
          end else if (out_free) begin
            load_out  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hw_r        <= HW_RESET;
      thr_r       <= THR_RESET;
      sum_r       <= '0;
      sq_r        <= '0;
      cnt_r       <= '0;
      fill_r      <= '0;
      wp_r        <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_HALF_WINDOW: begin
            hw_r   <= pwdata[HW_W-1:0];
            sum_r  <= '0;
            sq_r   <= '0;
            cnt_r  <= '0;
            fill_r <= '0;
            wp_r   <= '0;
          end
          REG_THRESHOLD: begin
            thr_r <= pwdata[THR_W-1:0];
          end
        endcase
      end
      if (acc) begin
        if (in_series_start) begin
          sum_r  <= '0;
          sq_r   <= '0;
          cnt_r  <= '0;
          fill_r <= '0;
          wp_r   <= '0;
          pos_r  <= POS_W'(1);
        end else if (pos_r != '1) begin
          pos_r <= pos_r + POS_W'(1);
        end
      end
      if (state_r == ST_UPD) begin
        sum_r  <= sum_r - old_term_r + x_ext;
        sq_r   <= sq_r - old_sq_r + x_sq_r;
        cnt_r  <= cnt_r - CNT_W'(drop_r) + CNT_W'(!miss_r);
        fill_r <= fill_base + CNT_W'(1);
        wp_r   <= wp_inc;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      x_r    <= in_sample_missing ? '0 : in_sample;
      miss_r <= in_sample_missing;
    end
    if (state_r == ST_OLD) begin
      drop_r     <= (fill_r >= len_c) && rd_ok;
      old_term_r <= ((fill_r >= len_c) && rd_ok) ? {{AW{rd_x[SB-1]}}, rd_x} : '0;
      old_sq_r   <= ((fill_r >= len_c) && rd_ok) ? SQ_W'(rd_sq) : '0;
      x_sq_r     <= SQ_W'(x_sq);
    end
    if (load_out) begin
      out_pos_r <= (pos_r == '1) ? pos_r : (pos_r - POS_W'(w_a));
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_HALF_WINDOW: prdata = CFG_DW'(hw_r);
      REG_THRESHOLD:   prdata = CFG_DW'(thr_r);
    endcase
  end

  assign out_valid            = out_valid_r;
  assign out_outlier_position = out_pos_r;

  rwzo_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_win_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rwzo_judge #(
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_judge (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (judge_go),
    .cnt    (cnt_r),
    .sum    (sum_r),
    .sum_sq (sq_r),
    .center (rd_x),
    .thr    (thr_r),
    .res    (jres)
  );

  a_out_from_judge: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_JUDGE || state_r == ST_EMIT))
    else $error("result raised outside the judge or emit state");

  a_fill_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= fill_r) && (fill_r <= len_c))
    else $error("valid count or fill level out of window bounds");

  a_done_in_judge: assert property (@(posedge clk) disable iff (!rst_n)
    jres.done |-> (state_r == ST_JUDGE))
    else $error("judge finished while sequencer not waiting");

endmodule

`default_nettype wire

// ----- tb/tb_rolling_window_zscore_outlier.sv -----
`timescale 1ns / 100ps

module tb_rolling_window_zscore_outlier import rwzo_pkg::*;;

  localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
  localparam int MAX_HW = MAX_HALF_WINDOW_DEF;
  localparam int DEPTH = 2 * MAX_HW + 1;
  localparam int SMP_MAX = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int SMP_MIN = -(1 << (SAMPLE_BITS - 1));
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int DRAIN_CYCLES = 24;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 215;

  typedef struct {
    logic [SAMPLE_BITS-1:0] sample;
    bit missing;
    bit start;
  } sample_item_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [SAMPLE_BITS-1:0] in_sample = '0;
  logic in_sample_missing = 1'b0;
  logic in_series_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [POS_W-1:0] out_outlier_position;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  sample_item_t pending_items[$];
  logic [POS_W-1:0] expected_positions[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int accepted_count = 0;
  int flagged_count = 0;
  int settings_count = 0;
  int cycle_count = 0;

  // window state of the predictor
  logic [HW_W-1:0] hw_cfg;
  logic [THR_W-1:0] thr_cfg;
  longint win_val[DEPTH];
  bit win_ok[DEPTH];
  longint win_sum;
  logic [127:0] win_sum_sq;
  int win_valid;
  int win_fill;
  logic [POS_W-1:0] series_pos;

  rolling_window_zscore_outlier dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sample(in_sample),
    .in_sample_missing(in_sample_missing),
    .in_series_start(in_series_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_outlier_position(out_outlier_position),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned magnitude(input longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic logic [127:0] square(input longint v);
    logic [127:0] m;
    m = 128'(magnitude(v));
    return m * m;
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < DEPTH; i++) begin
      win_val[i] = 0;
      win_ok[i] = 1'b0;
    end
    win_sum = 0;
    win_sum_sq = '0;
    win_valid = 0;
    win_fill = 0;
  endfunction

  // push one sample into the window, judge the center
  function automatic bit judge_sample(input logic signed [SAMPLE_BITS-1:0] smp,
                                      input bit missing, input bit start,
                                      output logic [POS_W-1:0] pos);
    int w;
    int len;
    longint x;
    longint c;
    logic [127:0] cq;
    logic [127:0] s2;
    logic [127:0] spread;
    logic [127:0] lhs;
    logic [127:0] rhs;
    longint unsigned dev;
    x = smp;
    pos = '0;
    if (hw_cfg == 0) begin
      w = 1;
    end else if (int'(hw_cfg) > MAX_HW) begin
      w = MAX_HW;
    end else begin
      w = int'(hw_cfg);
    end
    len = 2 * w + 1;
    if (start) begin
      clear_window();
      series_pos = '0;
    end
    if (series_pos != '1) series_pos++;
    if (win_fill >= len) begin
      if (win_ok[len-1]) begin
        win_sum -= win_val[len-1];
        win_sum_sq -= square(win_val[len-1]);
        win_valid--;
      end
      win_fill = len - 1;
    end
    for (int i = len - 1; i > 0; i--) begin
      win_val[i] = win_val[i-1];
      win_ok[i] = win_ok[i-1];
    end
    win_ok[0] = !missing;
    win_val[0] = missing ? 0 : x;
    if (!missing) begin
      win_sum += x;
      win_sum_sq += square(x);
      win_valid++;
    end
    win_fill++;
    if (win_fill < len || !win_ok[w] || win_valid < 2) return 1'b0;
    c = win_valid;
    cq = win_sum_sq * 128'(c);
    s2 = 128'(magnitude(win_sum)) * 128'(magnitude(win_sum));
    if (cq <= s2) return 1'b0;
    spread = cq - s2;
    dev = magnitude(c * win_val[w] - win_sum);
    lhs = 128'(dev) * 128'(dev) * (128'(c - 1) << LHS_SHIFT);
    rhs = spread * 128'(thr_cfg) * 128'(thr_cfg) * 128'(c);
    if (lhs <= rhs) return 1'b0;
    pos = (series_pos == '1) ? '1 : series_pos - POS_W'(w);
    return 1'b1;
  endfunction

  function automatic void push_item(input int value, input bit missing, input bit start);
    sample_item_t it;
    it.sample = value[SAMPLE_BITS-1:0];
    it.missing = missing;
    it.start = start;
    pending_items = {pending_items, it};
  endfunction

  // well-formed series around a base level, with spikes, gaps and some raw noise
  task automatic queue_random_items(input int n_items);
    int left;
    int run_len;
    int base;
    int spread;
    int v;
    sample_item_t it;
    left = n_items;
    while (left > 0) begin
      run_len = $urandom_range(150, 8);
      base = int'($urandom_range(8000000)) - 4000000;
      spread = 1 << $urandom_range(12);
      for (int k = 0; k < run_len && left > 0; k++) begin
        if ($urandom_range(99) < 12) begin
          it.sample = SAMPLE_BITS'($urandom);
          it.missing = 1'($urandom_range(1));
          it.start = ($urandom_range(19) == 0);
        end else begin
          v = base + int'($urandom_range(2 * spread)) - spread;
          if ($urandom_range(99) < 6) begin
            if ($urandom_range(1)) v += int'($urandom_range(4000000, spread * 8));
            else v -= int'($urandom_range(4000000, spread * 8));
          end
          it.sample = v[SAMPLE_BITS-1:0];
          it.missing = ($urandom_range(99) < 5);
          it.start = (k == 0);
        end
        pending_items = {pending_items, it};
        left--;
      end
    end
  endtask

  // write a register, then read it back
  task automatic program_reg(input reg_idx_t idx, input logic [CFG_DW-1:0] value);
    logic [CFG_DW-1:0] mask;
    mask = (idx == REG_HALF_WINDOW) ? CFG_DW'((1 << HW_W) - 1) : CFG_DW'((1 << THR_W) - 1);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_HALF_WINDOW) begin
      hw_cfg = value[HW_W-1:0];
      clear_window();
    end else begin
      thr_cfg = value[THR_W-1:0];
    end
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) != (value & mask)) begin
      $error("prdata: expected %0h, got %0h", value & mask, prdata & mask);
      mismatch_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_positions.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : drive_items
    sample_item_t next_item;
    logic [POS_W-1:0] flagged_pos;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        accepted_count++;
        if (judge_sample(in_sample, in_sample_missing, in_series_start, flagged_pos))
          expected_positions = {expected_positions, flagged_pos};
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = pending_items.pop_front();
          in_valid <= 1'b1;
          in_sample <= next_item.sample;
          in_sample_missing <= next_item.missing;
          in_series_start <= next_item.start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    logic [POS_W-1:0] want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_positions.size() == 0) begin
          $error("outlier_position: expected none, got %0d", out_outlier_position);
          mismatch_count++;
        end else begin
          want = expected_positions.pop_front();
          flagged_count++;
          if (out_outlier_position !== want) begin
            $error("outlier_position: expected %0d, got %0d", want, out_outlier_position);
            mismatch_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("rolling_window_zscore_outlier: mismatch");
    $finish;
  end

  initial begin
    hw_cfg = HW_RESET;
    thr_cfg = THR_RESET;
    clear_window();
    series_pos = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct <= 31;
    recv_idle_pct <= 82;
    settings_count = 1;

    // reset window: spike at the center, then the lowest value
    push_item(0, 1'b0, 1'b1);
    repeat (4) push_item(0, 1'b0, 1'b0);
    push_item(SMP_MAX, 1'b0, 1'b0);
    repeat (5) push_item(0, 1'b0, 1'b0);
    push_item(SMP_MIN, 1'b0, 1'b0);
    wait_drained();

    program_reg(REG_HALF_WINDOW, CFG_DW'(1));
    program_reg(REG_THRESHOLD, CFG_DW'(64));
    settings_count++;
    // single valid sample, flat window, missing center, restart, extremes
    push_item(SMP_MAX, 1'b1, 1'b0);
    push_item(7, 1'b0, 1'b0);
    push_item(SMP_MIN, 1'b1, 1'b0);
    repeat (3) push_item(5, 1'b0, 1'b0);
    push_item(5, 1'b0, 1'b0);
    push_item(-1, 1'b1, 1'b0);
    push_item(-5, 1'b0, 1'b0);
    push_item(SMP_MIN, 1'b0, 1'b1);
    push_item(SMP_MAX, 1'b0, 1'b0);
    push_item(SMP_MIN, 1'b0, 1'b0);
    wait_drained();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          program_reg(REG_HALF_WINDOW, CFG_DW'({$urandom, 5'd0}));
          program_reg(REG_THRESHOLD, CFG_DW'({$urandom, 16'd768}));
        end
        1: begin
          program_reg(REG_HALF_WINDOW, CFG_DW'(16));
          program_reg(REG_THRESHOLD, CFG_DW'(520));
        end
        2: begin
          program_reg(REG_HALF_WINDOW, CFG_DW'(3));
          program_reg(REG_THRESHOLD, CFG_DW'({$urandom, 16'hFFFF}));
        end
        3: begin
          program_reg(REG_HALF_WINDOW, CFG_DW'({$urandom, 5'd31}));
          program_reg(REG_THRESHOLD, CFG_DW'(0));
        end
        4: begin
          program_reg(REG_HALF_WINDOW, CFG_DW'(1));
          program_reg(REG_THRESHOLD, CFG_DW'(1));
        end
        default: begin
          program_reg(REG_HALF_WINDOW, CFG_DW'(8));
          program_reg(REG_THRESHOLD, CFG_DW'(300));
        end
      endcase
      settings_count++;
      if (phase < 2) begin
        send_idle_pct <= 31;
        recv_idle_pct <= 82;
      end else if (phase < 4) begin
        send_idle_pct <= 82;
        recv_idle_pct <= 31;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      queue_random_items(PHASE_ITEMS);
      wait_drained();
    end

    $display("fed %0d samples under %0d window/threshold settings", accepted_count,
             settings_count);
    $display("%0d flagged centers compared, %0d errors", flagged_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("rolling_window_zscore_outlier: match");
    end else begin
      $display("rolling_window_zscore_outlier: mismatch");
    end
    $finish;
  end

endmodule

// ----- rolling_window_zscore_outlier.f -----
hw/rtl/rwzo_pkg.sv
hw/rtl/rwzo_ram.sv
hw/rtl/rwzo_judge.sv
hw/rtl/rolling_window_zscore_outlier.sv
tb/tb_rolling_window_zscore_outlier.sv
